>>> hw/rtl/gppad_pkg.sv
// Shared types and constants for the pad bank update block.
package gppad_pkg;

  localparam int FIELD_W    = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int RNG_W      = 32;

  localparam logic [RNG_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [RNG_W-1:0] LCG_ADD = 32'd1013904223;
  localparam int               LCG_BIT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PULL_UP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_DOWN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_MODE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_SEED = 3'd6;

  localparam logic [1:0] FLT_ZERO = 2'd0;
  localparam logic [1:0] FLT_ONE  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
  } dp_cmd_t;

endpackage

>>> hw/rtl/gppad_ctrl.sv
// Controller: sequences one pin per cycle and owns the handshakes.
module gppad_ctrl #(
  parameter int NUM_PINS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gppad_pkg::dp_cmd_t cmd
);

  localparam int CntW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [CntW-1:0] LastPin = CntW'(NUM_PINS - 1);

  gppad_pkg::ctrl_state_t state, state_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gppad_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      gppad_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = LastPin;
          state_next = gppad_pkg::ST_RUN;
        end
      end
      gppad_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          state_next = gppad_pkg::ST_DONE;
        end else begin
          cnt_next = cnt - CntW'(1);
        end
      end
      gppad_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.store  = 1'b1;
          state_next = gppad_pkg::ST_IDLE;
        end
      end
      default: state_next = gppad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd.store) out_valid_next = 1'b1;
  end

endmodule

>>> hw/rtl/gppad_dp.sv
// Datapath: config registers, float generator, per-pin resolve and result words.
module gppad_dp #(
  parameter int NUM_PINS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gppad_pkg::dp_cmd_t                  cmd,
  input  logic                                cfg_we,
  input  logic [gppad_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gppad_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [gppad_pkg::FIELD_W-1:0]       ext_drive_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]       ext_level_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]       direction_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]       output_level_mask,
  output logic [gppad_pkg::FIELD_W-1:0]       pin_levels,
  output logic [gppad_pkg::FIELD_W-1:0]       input_levels,
  output logic [gppad_pkg::FIELD_W-1:0]       driven_mask
);

  localparam int FW = gppad_pkg::FIELD_W;
  localparam logic [FW-1:0] PinMask =
    (NUM_PINS >= FW) ? {FW{1'b1}} : ((FW'(1) << NUM_PINS) - FW'(1));

  logic [FW-1:0] pull_up, pull_dn, frc_lo, frc_hi, invert;
  logic [1:0]    flt_sel;
  logic [gppad_pkg::RNG_W-1:0] rng, rng_adv;

  logic [FW-1:0] drive_sh, level_sh, pu_sh, pd_sh, fl_sh, fh_sh;
  logic [FW-1:0] dir, olev, sel, inlev, drv;
  logic          undriven_float, lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pull_up <= '0;
      pull_dn <= {FW{1'b1}};
      frc_lo  <= '0;
      frc_hi  <= '0;
      invert  <= '0;
      flt_sel <= gppad_pkg::FLT_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gppad_pkg::REG_PULL_UP:    pull_up <= cfg_data[FW-1:0];
        gppad_pkg::REG_PULL_DOWN:  pull_dn <= cfg_data[FW-1:0];
        gppad_pkg::REG_FORCE_LOW:  frc_lo  <= cfg_data[FW-1:0];
        gppad_pkg::REG_FORCE_HIGH: frc_hi  <= cfg_data[FW-1:0];
        gppad_pkg::REG_INVERT:     invert  <= cfg_data[FW-1:0];
        gppad_pkg::REG_FLOAT_MODE: flt_sel <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign rng_adv = rng * gppad_pkg::LCG_MUL + gppad_pkg::LCG_ADD;
  assign undriven_float = !drive_sh[0] && !pu_sh[0] && !pd_sh[0];

  always_comb begin
    if (drive_sh[0]) begin
      lvl = level_sh[0];
    end else if (pu_sh[0]) begin
      lvl = 1'b1;
    end else if (pd_sh[0]) begin
      lvl = 1'b0;
    end else if (flt_sel == gppad_pkg::FLT_ZERO) begin
      lvl = 1'b0;
    end else if (flt_sel == gppad_pkg::FLT_ONE) begin
      lvl = 1'b1;
    end else begin
      lvl = rng_adv[gppad_pkg::LCG_BIT];
    end
    if (fl_sh[0]) lvl = 1'b0;
    if (fh_sh[0]) lvl = 1'b1;
  end

  // float generator: seed write reloads, random float pins advance it
  always_ff @(posedge clk) begin
    if (rst) begin
      rng <= '0;
    end else if (cfg_we && cfg_index == gppad_pkg::REG_FLOAT_SEED) begin
      rng <= cfg_data[gppad_pkg::RNG_W-1:0];
    end else if (cmd.step && undriven_float && flt_sel != gppad_pkg::FLT_ZERO
                 && flt_sel != gppad_pkg::FLT_ONE) begin
      rng <= rng_adv;
    end
  end

  // pin walk: bit 0 of each shifted copy is the current pin
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      drive_sh <= ext_drive_mask;
      level_sh <= ext_level_mask;
      pu_sh    <= pull_up;
      pd_sh    <= pull_dn;
      fl_sh    <= frc_lo;
      fh_sh    <= frc_hi;
      drv      <= ext_drive_mask;
      dir      <= direction_mask;
      olev     <= output_level_mask;
      sel      <= FW'(1);
      inlev    <= '0;
    end else if (cmd.step) begin
      drive_sh <= drive_sh >> 1;
      level_sh <= level_sh >> 1;
      pu_sh    <= pu_sh >> 1;
      pd_sh    <= pd_sh >> 1;
      fl_sh    <= fl_sh >> 1;
      fh_sh    <= fh_sh >> 1;
      sel      <= sel << 1;
      inlev    <= inlev | (sel & {FW{lvl}});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      pin_levels   <= (((dir & olev) | (~dir & inlev)) ^ invert) & PinMask;
      input_levels <= (inlev ^ invert) & PinMask;
      driven_mask  <= (drv | dir) & PinMask;
    end
  end

endmodule

>>> hw/rtl/gpio_pad_bank_pull_force_float.sv
// Top level of the pad bank update block: controller plus datapath.
// One input word is one update of the whole bank. Pins are resolved one per
// clock because the random float levels chain through a single 32-bit LCG
// step unit: after a word is accepted the pins are stepped in turn, then the
// result is stored into the output register. The input is stalled from
// acceptance until the result has been handed to the output register; a new
// word is then accepted even while that result is still stalled. Configuration
// writes take effect at the next clock; writing the seed register reloads the
// generator. Configure only while no word is in flight.
module gpio_pad_bank_pull_force_float #(
  parameter int NUM_PINS = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gppad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gppad_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gppad_pkg::FIELD_W-1:0]    ext_drive_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]    ext_level_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]    direction_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]    output_level_mask,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gppad_pkg::FIELD_W-1:0]    pin_levels,
  output logic [gppad_pkg::FIELD_W-1:0]    input_levels,
  output logic [gppad_pkg::FIELD_W-1:0]    driven_mask
);

  gppad_pkg::dp_cmd_t cmd;

  gppad_ctrl #(
    .NUM_PINS (NUM_PINS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gppad_dp #(
    .NUM_PINS (NUM_PINS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ext_drive_mask    (ext_drive_mask),
    .ext_level_mask    (ext_level_mask),
    .direction_mask    (direction_mask),
    .output_level_mask (output_level_mask),
    .pin_levels        (pin_levels),
    .input_levels      (input_levels),
    .driven_mask       (driven_mask)
  );

endmodule

>>> dv/pad_level_checker.sv
// Pad bank checker: tracks register writes, predicts each result word and compares it.
module pad_level_checker #(
  parameter int NUM_PINS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gppad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gppad_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [gppad_pkg::FIELD_W-1:0]     ext_drive_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]     ext_level_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]     direction_mask,
  input  logic [gppad_pkg::FIELD_W-1:0]     output_level_mask,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [gppad_pkg::FIELD_W-1:0]     pin_levels,
  input  logic [gppad_pkg::FIELD_W-1:0]     input_levels,
  input  logic [gppad_pkg::FIELD_W-1:0]     driven_mask,
  output int unsigned                       errors,
  output int unsigned                       waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [gppad_pkg::FIELD_W-1:0] pins;
    logic [gppad_pkg::FIELD_W-1:0] inputs;
    logic [gppad_pkg::FIELD_W-1:0] driven;
  } bank_view_t;

  localparam int LIVE_PINS =
    (NUM_PINS < gppad_pkg::FIELD_W) ? NUM_PINS : gppad_pkg::FIELD_W;
  localparam logic [gppad_pkg::FIELD_W-1:0] LIVE_SPAN =
    {gppad_pkg::FIELD_W{1'b1}} >> (gppad_pkg::FIELD_W - LIVE_PINS);

  logic [gppad_pkg::FIELD_W-1:0] up_mask, down_mask, low_mask, high_mask, inv_mask;
  logic [1:0]                    float_sel;
  logic [gppad_pkg::RNG_W-1:0]   rng;
  bank_view_t                    views_due[$];
  bank_view_t                    want;
  int unsigned                   fails;
  int unsigned                   results;

  // Resolve every pin in ascending order; random float pins step the LCG in that order.
  // Pins above the field width are undriven with no pull, so in random float mode they still step the LCG.
  function automatic bank_view_t settle_bank(input logic [gppad_pkg::FIELD_W-1:0] drive,
                                             level, dir, olev);
    bank_view_t  view;
    logic [63:0] d, lv, u, dn, lo, hi, seen;
    logic        lvl;
    d    = 64'(drive);
    lv   = 64'(level);
    u    = 64'(up_mask);
    dn   = 64'(down_mask);
    lo   = 64'(low_mask);
    hi   = 64'(high_mask);
    seen = '0;
    for (int p = 0; p < NUM_PINS && p < 64; p++) begin
      if (d[p]) begin
        lvl = lv[p];
      end else if (u[p]) begin
        lvl = 1'b1;
      end else if (dn[p]) begin
        lvl = 1'b0;
      end else if (float_sel == gppad_pkg::FLT_ZERO) begin
        lvl = 1'b0;
      end else if (float_sel == gppad_pkg::FLT_ONE) begin
        lvl = 1'b1;
      end else begin
        rng = rng * gppad_pkg::LCG_MUL + gppad_pkg::LCG_ADD;
        lvl = rng[gppad_pkg::LCG_BIT];
      end
      if (lo[p]) lvl = 1'b0;
      if (hi[p]) lvl = 1'b1;
      seen[p] = lvl;
    end
    view.pins   = (((dir & olev) | (~dir & seen[gppad_pkg::FIELD_W-1:0])) ^ inv_mask)
                  & LIVE_SPAN;
    view.inputs = (seen[gppad_pkg::FIELD_W-1:0] ^ inv_mask) & LIVE_SPAN;
    view.driven = (drive | dir) & LIVE_SPAN;
    return view;
  endfunction

  task automatic note(input string what, input logic [gppad_pkg::FIELD_W-1:0] exp_v, got_v);
    fails++;
    if (fails <= 10)
      $display("result word %0d %s: expected %h, got %h", results, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      up_mask   = '0;
      down_mask = '1;
      low_mask  = '0;
      high_mask = '0;
      inv_mask  = '0;
      float_sel = gppad_pkg::FLT_ZERO;
      rng       = '0;
      views_due.delete();
      fails     = 0;
      results   = 0;
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          gppad_pkg::REG_PULL_UP:    up_mask   = cfg_data;
          gppad_pkg::REG_PULL_DOWN:  down_mask = cfg_data;
          gppad_pkg::REG_FORCE_LOW:  low_mask  = cfg_data;
          gppad_pkg::REG_FORCE_HIGH: high_mask = cfg_data;
          gppad_pkg::REG_INVERT:     inv_mask  = cfg_data;
          gppad_pkg::REG_FLOAT_MODE: float_sel = cfg_data[1:0];
          gppad_pkg::REG_FLOAT_SEED: rng       = cfg_data[gppad_pkg::RNG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        views_due.push_back(settle_bank(ext_drive_mask, ext_level_mask,
                                        direction_mask, output_level_mask));
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (views_due.size() == 0) begin
          note("arrived with nothing due, pin_levels", 'x, pin_levels);
        end else begin
          want = views_due.pop_front();
          if (pin_levels !== want.pins) note("pin_levels", want.pins, pin_levels);
          if (input_levels !== want.inputs) note("input_levels", want.inputs, input_levels);
          if (driven_mask !== want.driven) note("driven_mask", want.driven, driven_mask);
        end
        results++;
      end
    end
    errors  <= fails;
    waiting <= views_due.size();
  end

endmodule

>>> dv/gpio_pad_bank_pull_force_float_tb.sv
// Testbench top for the pad bank update block: stimulus, stall patterns and verdict.
module gpio_pad_bank_pull_force_float_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                      FLOAT_RAND     = 2'd2;
  localparam logic [1:0]                      FLOAT_RAND_ALT = 2'd3;
  localparam logic [gppad_pkg::CFG_IDX_W-1:0] REG_SPARE      = 3'd7;
  localparam logic [gppad_pkg::FIELD_W-1:0]   ALL_ONES       = {gppad_pkg::FIELD_W{1'b1}};
  localparam int                              WORDS_PER_SET  = 120;
  localparam int                              RAND_SETS      = 7;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [gppad_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gppad_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic [gppad_pkg::FIELD_W-1:0]    ext_drive_mask;
  logic [gppad_pkg::FIELD_W-1:0]    ext_level_mask;
  logic [gppad_pkg::FIELD_W-1:0]    direction_mask;
  logic [gppad_pkg::FIELD_W-1:0]    output_level_mask;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [gppad_pkg::FIELD_W-1:0]    pin_levels;
  logic [gppad_pkg::FIELD_W-1:0]    input_levels;
  logic [gppad_pkg::FIELD_W-1:0]    driven_mask;
  int unsigned                      errors;
  int unsigned                      waiting;
  logic                             quiet = 1'b0;
  int                               stall_hold = 0;
  int                               words_sent;
  int                               settings;

  gpio_pad_bank_pull_force_float uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .ext_drive_mask    (ext_drive_mask),
    .ext_level_mask    (ext_level_mask),
    .direction_mask    (direction_mask),
    .output_level_mask (output_level_mask),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pin_levels        (pin_levels),
    .input_levels      (input_levels),
    .driven_mask       (driven_mask)
  );

  pad_level_checker pad_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .ext_drive_mask    (ext_drive_mask),
    .ext_level_mask    (ext_level_mask),
    .direction_mask    (direction_mask),
    .output_level_mask (output_level_mask),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pin_levels        (pin_levels),
    .input_levels      (input_levels),
    .driven_mask       (driven_mask),
    .errors            (errors),
    .waiting           (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("gpio_pad_bank_pull_force_float verification failed");
    $finish;
  end

  // short random stalls, and now and then a long one that backs up the input side
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      out_stall  <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(99) < 12) begin
      out_stall  <= 1'b1;
      stall_hold <= ($urandom_range(49) == 0) ? $urandom_range(30, 110) : 0;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  function automatic logic [gppad_pkg::FIELD_W-1:0] wide_rand();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[gppad_pkg::FIELD_W-1:0];
  endfunction

  function automatic logic [gppad_pkg::FIELD_W-1:0] pick_mask();
    logic [gppad_pkg::FIELD_W-1:0] m;
    case ($urandom_range(5))
      0: m = '0;
      1: m = ALL_ONES;
      2: m = wide_rand();
      3: m = wide_rand() & wide_rand();
      4: m = wide_rand() | wide_rand();
      default: begin
        m = '0;
        m[$urandom_range(gppad_pkg::FIELD_W-1)] = 1'b1;
      end
    endcase
    return m;
  endfunction

  task automatic put_word(input logic [gppad_pkg::FIELD_W-1:0] drive, level, dir, olev);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    ext_drive_mask    <= drive;
    ext_level_mask    <= level;
    direction_mask    <= dir;
    output_level_mask <= olev;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gppad_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gppad_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // bits above the mode and seed fields carry noise
  task automatic set_bank(input logic [gppad_pkg::FIELD_W-1:0] up, down, lo, hi, inv,
                          input logic [1:0] mode, input logic [gppad_pkg::RNG_W-1:0] seed);
    logic [gppad_pkg::CFG_DATA_W-1:0] word;
    write_reg(gppad_pkg::REG_PULL_UP, up);
    write_reg(gppad_pkg::REG_PULL_DOWN, down);
    write_reg(gppad_pkg::REG_FORCE_LOW, lo);
    write_reg(gppad_pkg::REG_FORCE_HIGH, hi);
    write_reg(gppad_pkg::REG_INVERT, inv);
    word = wide_rand();
    word[1:0] = mode;
    write_reg(gppad_pkg::REG_FLOAT_MODE, word);
    word = wide_rand();
    word[gppad_pkg::RNG_W-1:0] = seed;
    write_reg(gppad_pkg::REG_FLOAT_SEED, word);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  initial begin
    logic [1:0]                  mode;
    logic [gppad_pkg::RNG_W-1:0] seed;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= gppad_pkg::REG_PULL_UP;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    ext_drive_mask    <= '0;
    ext_level_mask    <= '0;
    direction_mask    <= '0;
    output_level_mask <= '0;
    words_sent = 0;
    settings   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: everything undriven pulls low
    put_word('0, '0, '0, '0);
    put_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    put_word('0, ALL_ONES, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);

    // mixed pulls (both on some pins), both forces, inversion over forced pins, random float
    drain();
    set_bank(48'h5555_5555_5555, 48'h3333_3333_3333, 48'h0F0F_0F0F_0F0F,
             48'h00FF_00FF_00FF, 48'hFFFF_0000_FFFF, FLOAT_RAND, 32'h1234_5678);
    put_word('0, '0, '0, '0);
    put_word('0, ALL_ONES, '0, ALL_ONES);
    put_word(48'hF0F0_F0F0_F0F0, 48'hCCCC_CCCC_CCCC, '0, wide_rand());
    put_word(ALL_ONES, wide_rand(), 48'hFFFF_0000_00FF, wide_rand());

    // no pulls at all, float mode three, seed all ones, everything inverted
    drain();
    set_bank('0, '0, '0, '0, ALL_ONES, FLOAT_RAND_ALT, '1);
    put_word('0, '0, '0, '0);
    put_word(48'h8000_0000_0001, ALL_ONES, '0, '0);
    put_word('0, '0, ALL_ONES, 48'h1234_5678_9ABC);

    // float high, force low everywhere with force high over the upper half
    drain();
    set_bank('0, '0, ALL_ONES, 48'hFFFF_FF00_0000, 48'h0000_FF00_00FF,
             gppad_pkg::FLT_ONE, '0);
    write_reg(REG_SPARE, ALL_ONES);
    cfg_we <= 1'b0;
    @(posedge clk);
    put_word('0, '0, '0, '0);
    put_word(ALL_ONES, '0, 48'h0000_0000_FFFF, ALL_ONES);
    put_word(wide_rand(), wide_rand(), wide_rand(), wide_rand());

    // both pulls everywhere: pull-up wins
    drain();
    set_bank(ALL_ONES, ALL_ONES, '0, '0, '0, gppad_pkg::FLT_ZERO, '0);
    put_word('0, '0, '0, '0);
    put_word(48'h0000_FFFF_0000, '0, '0, '0);

    // float low, no pulls
    drain();
    set_bank('0, '0, '0, '0, '0, gppad_pkg::FLT_ZERO, '1);
    put_word('0, ALL_ONES, '0, ALL_ONES);
    put_word(48'hAAAA_AAAA_AAAA, ALL_ONES, 48'h0000_0000_00FF, '0);

    for (int s = 0; s < RAND_SETS; s++) begin
      drain();
      if ($urandom_range(9) < 6)
        mode = $urandom_range(1) ? FLOAT_RAND : FLOAT_RAND_ALT;
      else
        mode = $urandom_range(1) ? gppad_pkg::FLT_ONE : gppad_pkg::FLT_ZERO;
      case ($urandom_range(3))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = $urandom;
      endcase
      set_bank(pick_mask(), pick_mask(), pick_mask(), pick_mask(), pick_mask(), mode, seed);
      quiet <= (s == 3);
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        if (s == 1 && n == WORDS_PER_SET / 2) drain();
        put_word(pick_mask(), pick_mask(), pick_mask(), pick_mask());
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("%0d bank updates sent under %0d register settings", words_sent, settings);
    $display("pull priority, both forces, inversion and all four float modes exercised");
    if (errors == 0)
      $display("gpio_pad_bank_pull_force_float verification clean");
    else
      $display("gpio_pad_bank_pull_force_float verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/gppad_pkg.sv
hw/rtl/gppad_ctrl.sv
hw/rtl/gppad_dp.sv
hw/rtl/gpio_pad_bank_pull_force_float.sv
dv/pad_level_checker.sv
dv/gpio_pad_bank_pull_force_float_tb.sv
